>>> rtl/core/rciv_pkg.sv
// Package for the rating curve inverse lookup: sizes, command and register
// codes, controller state types and the saturation helper.
// No dependencies.
`default_nettype none

package rciv_pkg;

  // Rating table geometry
  localparam int unsigned TableDepth = 256;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned DataW      = 32;
  localparam int unsigned HgtW       = DataW + IdxW;

  // Request codes
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgHeightStep = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEntryCount = 2'd1;

  // Reset values of the configuration registers
  localparam logic [DataW-1:0] HeightStepRst = 32'd655;
  localparam logic [CntW-1:0]  EntryCountRst = '0;

  typedef enum logic [2:0] {
    StIdle,
    StSrch,
    StMul,
    StEval,
    StDiv
  } state_e;

  // How the located segment is finished
  typedef enum logic [1:0] {
    ModeAbove,
    ModeMid,
    ModeInterp
  } mode_e;

  // Clamp a widened height to the 32-bit level range
  function automatic logic [DataW-1:0] sat_level(input logic [HgtW:0] v);
    logic [DataW-1:0] res;
    if (|v[HgtW:DataW]) begin
      res = '1;
    end else begin
      res = v[DataW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rciv_div.sv
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on rciv_pkg. The numerator's upper half must be below the divisor.
`default_nettype none

module rciv_div import rciv_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [2*DataW-1:0] num_i,
  input  wire logic [DataW-1:0]   den_i,
  output logic                    done_o,
  output logic [DataW-1:0]        quot_o
);

  localparam int unsigned StepW = $clog2(DataW);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] lo_q, lo_d;
  logic [DataW-1:0] den_q, den_d;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    trial  = {rem_q, lo_q[DataW-1]};
    diff   = trial - {1'b0, den_q};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    den_d  = den_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = num_i[2*DataW-1:DataW];
      lo_d  = num_i[DataW-1:0];
      den_d = den_i;
    end else if (run_q) begin
      if (!diff[DataW]) begin
        rem_d = diff[DataW-1:0];
        lo_d  = {lo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = trial[DataW-1:0];
        lo_d  = {lo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q + StepW'(1);
      if (cnt_q == StepW'(DataW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = lo_q;

endmodule

`default_nettype wire

>>> rtl/core/rating_curve_inverse_lookup.sv
// Rating curve inverse lookup: holds a discharge-per-height-step table and
// turns a discharge into an interpolated water height. Depends on rciv_pkg
// and rciv_div.
`default_nettype none

// A request is taken when start_i is high and busy_o low; one request is in
// flight at a time. A table write gives no result. A query gives one result,
// shown for a single cycle with done_o high; the receiver cannot stall it.
// Negative or zero discharge and an empty table answer in the cycle after the
// request is taken. Otherwise the table memory is scanned one entry per cycle
// through its single read port (k entries scanned, k at most entry_count),
// then the height and product multiplies are registered, and for a true
// interpolation the bit-serial divider runs before the result is given. The
// table needs no clearing after reset; entries must be written before they are
// used. Configuration writes are to be made only while busy_o is low.
module rating_curve_inverse_lookup import rciv_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Request channel
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic               cmd_i,
  input  wire logic [IdxW-1:0]    entry_index_i,
  input  wire logic [DataW-1:0]   entry_flow_i,
  input  wire logic signed [DataW-1:0] query_flow_i,
  // Result channel
  output logic                    done_o,
  output logic [DataW-1:0]        level_o,
  output logic                    ok_o,
  // Configuration port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DataW-1:0]   cfg_wdata_i
);

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  logic [DataW-1:0]   step_q;
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    n_used;

  logic [IdxW-1:0]    idx_q, idx_d;
  logic [IdxW-1:0]    fac_q, fac_d;
  logic [DataW-1:0]   q_q, q_d;
  logic [DataW-1:0]   q1_q, q1_d;
  logic [DataW-1:0]   q2_q, q2_d;
  logic [HgtW-1:0]    h_q;
  logic [2*DataW-1:0] prod_q;

  logic               done_q, done_d;
  logic [DataW-1:0]   level_q, level_d;
  logic               ok_q, ok_d;

  logic [DataW-1:0]   mem [TableDepth];
  logic [DataW-1:0]   rdata_q;
  logic [IdxW-1:0]    raddr;
  logic               mem_we;
  logic               accept;

  logic               div_start;
  logic               div_done;
  logic [DataW-1:0]   div_quot;

  assign accept = start_i && !busy_o;
  assign n_used = (count_q > CntW'(TableDepth)) ? CntW'(TableDepth) : count_q;

  // Controller: next state and datapath selects
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    idx_d     = idx_q;
    fac_d     = fac_q;
    q_d       = q_q;
    q1_d      = q1_q;
    q2_d      = q2_q;
    done_d    = 1'b0;
    level_d   = level_q;
    ok_d      = ok_q;
    raddr     = '0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    case (state_q)
      StIdle: begin
        // Entry 0 is fetched up front so the scan starts next cycle
        if (accept) begin
          if (cmd_i == CmdWrite) begin
            mem_we = 1'b1;
          end else begin
            q_d = query_flow_i;
            if (query_flow_i[DataW-1]) begin
              done_d  = 1'b1;
              level_d = '0;
              ok_d    = 1'b0;
            end else if (query_flow_i == '0) begin
              done_d  = 1'b1;
              level_d = '0;
              ok_d    = 1'b1;
            end else if (n_used == '0) begin
              done_d  = 1'b1;
              level_d = '0;
              ok_d    = 1'b0;
            end else begin
              idx_d   = '0;
              state_d = StSrch;
            end
          end
        end
      end
      StSrch: begin
        // rdata_q holds entry idx_q; the next one is requested meanwhile
        raddr = idx_q + IdxW'(1);
        if (rdata_q >= q_q) begin
          if (idx_q == '0) begin
            done_d  = 1'b1;
            level_d = '0;
            ok_d    = 1'b1;
            state_d = StIdle;
          end else begin
            q2_d    = rdata_q;
            fac_d   = idx_q - IdxW'(1);
            mode_d  = (rdata_q <= q1_q) ? ModeMid : ModeInterp;
            state_d = StMul;
          end
        end else if (({1'b0, idx_q} + CntW'(1)) == n_used) begin
          fac_d   = idx_q;
          mode_d  = ModeAbove;
          state_d = StMul;
        end else begin
          q1_d  = rdata_q;
          idx_d = idx_q + IdxW'(1);
        end
      end
      StMul: begin
        state_d = StEval;
      end
      StEval: begin
        case (mode_q)
          ModeAbove: begin
            done_d  = 1'b1;
            level_d = sat_level({1'b0, h_q});
            ok_d    = 1'b0;
            state_d = StIdle;
          end
          ModeMid: begin
            // floor((h1 + h2) / 2) with h2 = h1 + step
            done_d  = 1'b1;
            level_d = sat_level({1'b0, h_q} + (HgtW + 1)'(step_q >> 1));
            ok_d    = 1'b1;
            state_d = StIdle;
          end
          ModeInterp: begin
            div_start = 1'b1;
            state_d   = StDiv;
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end
      StDiv: begin
        if (div_done) begin
          done_d  = 1'b1;
          level_d = sat_level({1'b0, h_q} + (HgtW + 1)'(div_quot));
          ok_d    = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      step_q  <= HeightStepRst;
      count_q <= EntryCountRst;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgHeightStep: step_q  <= cfg_wdata_i;
          CfgEntryCount: count_q <= cfg_wdata_i[CntW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers and the two multiplies
  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    idx_q   <= idx_d;
    fac_q   <= fac_d;
    q_q     <= q_d;
    q1_q    <= q1_d;
    q2_q    <= q2_d;
    level_q <= level_d;
    ok_q    <= ok_d;
    if (state_q == StMul) begin
      h_q    <= {{DataW{1'b0}}, fac_q} * {{IdxW{1'b0}}, step_q};
      prod_q <= {{DataW{1'b0}}, q_q - q1_q} * {{DataW{1'b0}}, step_q};
    end
  end

  // Rating table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[entry_index_i] <= entry_flow_i;
    end
    rdata_q <= mem[raddr];
  end

  rciv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (q2_q - q1_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign busy_o  = (state_q != StIdle);
  assign done_o  = done_q;
  assign level_o = level_q;
  assign ok_o    = ok_q;

  // A result is only given once the controller is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result while busy");

  // A table write never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CmdWrite) |=> !done_o)
    else $error("result after table write");

  // A query either answers at once or keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CmdQuery) |=> (busy_o || done_o))
    else $error("query dropped");

  // The scan never runs past the entries in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSrch) |-> ({1'b0, idx_q} < n_used))
    else $error("scan beyond table");

  // The divider only reports while its result is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("stray divider result");

endmodule

`default_nettype wire

>>> bench/rating_curve_inverse_lookup_tb.sv
// Self-checking bench for rating_curve_inverse_lookup: table writes and height
// queries against an in-bench height predictor, with randomised pacing.
// Depends on rciv_pkg and the rating_curve_inverse_lookup RTL.
`default_nettype none

module rating_curve_inverse_lookup_tb import rciv_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandItems  = 1150;
  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned TailWait   = 320;
  // Register indexes that select no register
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef struct {
    logic                    cmd;
    logic [IdxW-1:0]         idx;
    logic [DataW-1:0]        eflow;
    logic signed [DataW-1:0] qflow;
  } request_t;

  typedef struct {
    logic [DataW-1:0] level;
    logic             ok;
  } height_t;

  // DUT connections, inputs all known from time zero
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    cmd_i = CmdWrite;
  logic [IdxW-1:0]         entry_index_i = '0;
  logic [DataW-1:0]        entry_flow_i = '0;
  logic signed [DataW-1:0] query_flow_i = '0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i = '0;
  logic [DataW-1:0]        cfg_wdata_i = '0;
  logic                    busy_o;
  logic                    done_o;
  logic [DataW-1:0]        level_o;
  logic                    ok_o;

  rating_curve_inverse_lookup dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .entry_index_i(entry_index_i),
    .entry_flow_i (entry_flow_i),
    .query_flow_i (query_flow_i),
    .done_o       (done_o),
    .level_o      (level_o),
    .ok_o         (ok_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Predictor state: table contents and register copies
  logic [DataW-1:0] curve_tab [TableDepth];
  logic [DataW-1:0] step_cfg = HeightStepRst;
  logic [CntW-1:0]  count_cfg = EntryCountRst;

  // Stimulus planning: what has been queued for writing so far
  logic [DataW-1:0] plan_tab [TableDepth];
  bit               plan_written [TableDepth];

  request_t request_q [$];
  height_t  expected_levels [$];
  request_t next_req;
  height_t  got_exp;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_queries = 0;
  int unsigned n_writes = 0;
  int unsigned n_settings = 0;
  int unsigned n_rand = 0;
  int unsigned gap = 0;
  bit          idle_on = 1'b0;
  bit          steady = 1'b0;
  bit          hold_drain = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Expected height for a query, given the current table and registers
  function automatic height_t lookup_height(input logic [DataW-1:0] q);
    height_t     r;
    int unsigned n, i;
    logic [63:0] lv, q1, q2, h1, h2, st;
    st = 64'(step_cfg);
    n = (count_cfg > TableDepth) ? TableDepth : count_cfg;
    r.ok = 1'b1;
    lv = '0;
    if (q[DataW-1]) begin
      r.ok = 1'b0;
    end else if (q != '0) begin
      i = 0;
      while (i < n && curve_tab[i] < q) i++;
      if (i == n) begin
        // beyond the last entry in use: top height, flagged
        lv = (n == 0) ? 64'd0 : 64'(n - 1) * st;
        r.ok = 1'b0;
      end else if (i != 0) begin
        q1 = 64'(curve_tab[i-1]);
        q2 = 64'(curve_tab[i]);
        h1 = 64'(i - 1) * st;
        h2 = 64'(i) * st;
        // flat segment cannot be found by the search, kept for safety
        if (q2 <= q1) begin
          lv = (h1 + h2) >> 1;
        end else begin
          lv = h1 + ((64'(q) - q1) * st) / (q2 - q1);
        end
      end
    end
    r.level = (lv > 64'hFFFF_FFFF) ? '1 : lv[DataW-1:0];
    return r;
  endfunction

  // Every entry a search may touch has been written
  function automatic bit plan_ready();
    int unsigned n;
    bit          ready;
    n = (count_cfg > TableDepth) ? TableDepth : count_cfg;
    ready = 1'b1;
    for (int k = 0; k < n; k++) if (!plan_written[k]) ready = 1'b0;
    return ready;
  endfunction

  task automatic push_write(input logic [IdxW-1:0] idx, input logic [DataW-1:0] flow);
    request_t r;
    r.cmd = CmdWrite;
    r.idx = idx;
    r.eflow = flow;
    r.qflow = $urandom;
    request_q.insert(request_q.size(), r);
    plan_tab[idx] = flow;
    plan_written[idx] = 1'b1;
  endtask

  task automatic push_query(input logic [DataW-1:0] q);
    request_t r;
    r.cmd = CmdQuery;
    r.idx = IdxW'($urandom);
    r.eflow = $urandom;
    // never let a search reach an unwritten entry
    r.qflow = (!q[DataW-1] && q != '0 && !plan_ready()) ? '0 : q;
    request_q.insert(request_q.size(), r);
  endtask

  // Block idle: nothing queued, nothing expected, nothing in flight
  task automatic wait_idle();
    do @(posedge clk_i);
    while (request_q.size() != 0 || expected_levels.size() != 0 || start_i || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CfgHeightStep) step_cfg = val;
    else if (idx == CfgEntryCount) count_cfg = val[CntW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // One random phase: registers, a table, then queries mixed with rewrites
  task automatic run_phase();
    logic [DataW-1:0] step_v, q;
    logic [CntW-1:0]  cnt;
    logic [63:0]      acc, inc_max, lo, hi;
    int unsigned      n, style, nq, k, seg;
    wait_idle();
    steady = (n_rand + 120 >= RandItems);
    idle_on = !steady && ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 7))
      0: step_v = 32'd1;
      1: step_v = 32'hFFFF_FFFF;
      2: step_v = '0;
      3: step_v = HeightStepRst;
      4: step_v = 32'h0001_0000;
      5, 6: step_v = $urandom_range(1, 32'h0010_0000);
      default: step_v = $urandom;
    endcase
    k = $urandom_range(0, 19);
    if (k == 0) cnt = '0;
    else if (k == 1) cnt = CntW'(1);
    else if (k == 2) cnt = CntW'(2);
    else if (k < 14) cnt = CntW'($urandom_range(3, 16));
    else if (k < 18) cnt = CntW'($urandom_range(17, 64));
    else if (k == 18) cnt = CntW'(TableDepth);
    else cnt = CntW'($urandom_range(TableDepth + 1, 511));
    if ($urandom_range(0, 1) == 0) begin
      set_reg(CfgHeightStep, step_v);
      set_reg(CfgEntryCount, {($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'd0, cnt});
    end else begin
      set_reg(CfgEntryCount, {23'd0, cnt});
      set_reg(CfgHeightStep, step_v);
    end
    // spare indexes must leave both registers alone
    if ($urandom_range(0, 3) == 0)
      set_reg(($urandom_range(0, 1) != 0) ? CfgSpareA : CfgSpareB, $urandom);
    n = (cnt > TableDepth) ? TableDepth : cnt;

    // monotone table for most phases, a scrambled one now and then
    style = $urandom_range(0, 5);
    case (style)
      0: begin
        acc = 64'($urandom_range(0, 1000));
        inc_max = 64'hFFFF_FFFF / (n + 1);
      end
      1: begin
        acc = 64'($urandom_range(0, 10));
        inc_max = 64'd3;
      end
      default: begin
        acc = 64'($urandom_range(0, 32'h0002_0000));
        inc_max = 64'h0002_0000;
      end
    endcase
    for (int e = 0; e < n; e++) begin
      if (style == 2) push_write(IdxW'(e), $urandom);
      else push_write(IdxW'(e), (acc > 64'hFFFF_FFFF) ? '1 : acc[DataW-1:0]);
      acc += 64'($urandom) % (inc_max + 1);
    end
    n_rand += n;
    // entries beyond the part in use are never searched
    if (n < TableDepth) begin
      for (int e = 0; e < $urandom_range(0, 3); e++) begin
        push_write(IdxW'($urandom_range(n, TableDepth - 1)), $urandom);
        n_rand++;
      end
    end

    nq = (n > 64) ? $urandom_range(8, 16) : $urandom_range(15, 45);
    for (int j = 0; j < nq; j++) begin
      k = $urandom_range(0, 9);
      if (n == 0 && k >= 2 && k <= 7) k = 8;
      case (k)
        0: q = {1'b1, 31'($urandom)};
        1: q = '0;
        2: q = plan_tab[$urandom_range(0, n - 1)];
        3: q = plan_tab[$urandom_range(0, n - 1)] + (($urandom_range(0, 1) != 0) ? 32'd1 : '1);
        4, 5, 6: begin
          if (n < 2) begin
            q = $urandom;
          end else begin
            seg = $urandom_range(1, n - 1);
            lo = 64'(plan_tab[seg-1]);
            hi = 64'(plan_tab[seg]);
            q = (hi > lo) ? DataW'(lo + 1 + (64'($urandom) % (hi - lo))) : $urandom;
          end
        end
        7: begin
          acc = 64'(plan_tab[n-1]) + 64'($urandom_range(1, 1000));
          q = (acc > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc[DataW-1:0];
        end
        8: q = $urandom;
        default: q = '0;
      endcase
      // rewrite noise instead of a query
      if (k == 9) push_write(IdxW'($urandom), $urandom);
      else push_query(q);
      n_rand++;
    end
  endtask

  // Driver: presents queued requests, holds each until taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        if (cmd_i == CmdWrite) begin
          curve_tab[entry_index_i] = entry_flow_i;
          n_writes++;
        end else begin
          expected_levels.insert(expected_levels.size(), lookup_height(query_flow_i));
          n_queries++;
          if (!steady && $urandom_range(0, 49) == 0) hold_drain = 1'b1;
        end
        if (idle_on && !steady && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
      end
      if (hold_drain && expected_levels.size() == 0) hold_drain = 1'b0;
      if (!(start_i && busy_o)) begin
        if (gap != 0) begin
          gap--;
          start_i <= 1'b0;
        end else if (hold_drain || request_q.size() == 0) begin
          start_i <= 1'b0;
        end else begin
          next_req = request_q.pop_front();
          start_i <= 1'b1;
          cmd_i <= next_req.cmd;
          entry_index_i <= next_req.idx;
          entry_flow_i <= next_req.eflow;
          query_flow_i <= next_req.qflow;
        end
      end
    end
  end

  // Monitor: each result against the oldest expected height
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (expected_levels.size() == 0) begin
        $error("unexpected result: level %h ok %b", level_o, ok_o);
        errors++;
      end else begin
        got_exp = expected_levels.pop_front();
        if (level_o !== got_exp.level) begin
          $error("level: expected %h, actual %h", got_exp.level, level_o);
          errors++;
        end
        if (ok_o !== got_exp.ok) begin
          $error("ok: expected %b, actual %b", got_exp.ok, ok_o);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int e = 0; e < TableDepth; e++) begin
      curve_tab[e] = '0;
      plan_tab[e] = '0;
      plan_written[e] = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_on = 1'b1;

    // Directed: empty table with reset registers
    push_query(32'h0001_0000);
    push_query(32'h8000_0000);
    push_query('0);
    // table with a flat segment and extreme indexes/values
    push_write(8'd0, '0);
    push_write(8'd1, 32'd1000);
    push_write(8'd2, 32'd1000);
    push_write(8'd3, 32'h7FFF_FFFE);
    push_write(8'd255, 32'hFFFF_FFFF);
    wait_idle();
    set_reg(CfgEntryCount, 32'd4);
    push_query(32'd1);
    push_query(32'd500);
    push_query(32'd1000);
    push_query(32'd1001);
    push_query(32'h7FFF_FFFE);
    push_query(32'h7FFF_FFFF);
    push_query('1);
    push_query('0);
    // widest step: heights saturate
    wait_idle();
    set_reg(CfgHeightStep, 32'hFFFF_FFFF);
    push_query(32'h7FFF_FFFE);
    push_query(32'h7FFF_FFFF);
    push_query(32'd1001);
    push_query(32'd500);
    // zero step, then a single entry in use
    wait_idle();
    set_reg(CfgHeightStep, '0);
    set_reg(CfgSpareA, $urandom);
    push_query(32'd500);
    wait_idle();
    set_reg(CfgHeightStep, 32'd1);
    set_reg(CfgEntryCount, 32'd1);
    push_query(32'd5);

    // Random phases
    while (n_rand < RandItems) run_phase();

    do @(posedge clk_i);
    while (request_q.size() != 0 || expected_levels.size() != 0 || start_i);
    repeat (TailWait) @(posedge clk_i);
    if (expected_levels.size() != 0) begin
      $error("%0d expected results never arrived", expected_levels.size());
      errors++;
    end
    $display("Ran %0d queries and %0d table writes over %0d register writes,",
             n_queries, n_writes, n_settings);
    $display("table sizes 0 to 511 (clamped), steps from zero to full scale.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/core/rciv_pkg.sv
rtl/core/rciv_div.sv
rtl/core/rating_curve_inverse_lookup.sv
bench/rating_curve_inverse_lookup_tb.sv
